>>> design/gtcr_pkg.sv
// Package for the segmented GLCD text renderer.
// Holds codes, state and command types, and the 5x7 font table.
// No dependencies.
package gtcr_pkg;

  localparam int unsigned DEF_TEXT_COLUMNS = 32;
  localparam int unsigned DEF_TEXT_ROWS    = 8;
  localparam int unsigned STORE_DEPTH      = 256;

  localparam logic [5:0] SPLIT_A    = 6'd11;
  localparam logic [5:0] SPLIT_B    = 6'd22;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] BLANK_BYTE = 8'h00;
  localparam logic [6:0] SEG_WIDTH  = 7'd64;

  localparam logic [2:0] OP_DATA  = 3'd0;
  localparam logic [2:0] OP_COL   = 3'd1;
  localparam logic [2:0] OP_PAGE  = 3'd2;
  localparam logic [2:0] OP_ON    = 3'd3;
  localparam logic [2:0] OP_START = 3'd4;

  localparam logic [1:0] SEG_ALL = 2'd3;

  typedef enum logic [2:0] {
    K_INIT  = 3'd0,
    K_PRINT = 3'd1,
    K_MOVE  = 3'd2,
    K_CLEAR = 3'd3,
    K_TICK  = 3'd4,
    K_MPTR  = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ON, ST_START, ST_CLR_PAGE, ST_CLR_COL, ST_CLR_DATA,
    ST_PTR_COL, ST_PTR_PAGE, ST_DRAW, ST_SPL_COL, ST_SPL_PAGE,
    ST_CUR_COL, ST_CUR_PAGE
  } state_e;

  typedef enum logic [2:0] {
    JOB_INIT, JOB_CLEAR, JOB_MOVE, JOB_PRINT, JOB_TICK
  } job_e;

  // Actions taken by the datapath when a request is accepted
  typedef enum logic [2:0] {
    ACT_NONE, ACT_INIT, ACT_PRINT, ACT_MOVE, ACT_CLEAR, ACT_TICK, ACT_MPTR
  } act_e;

  typedef enum logic [3:0] {
    SEL_ON, SEL_START, SEL_CLR_PAGE, SEL_CLR_COL, SEL_CLR_DATA,
    SEL_PTR_COL, SEL_PTR_PAGE, SEL_GLYPH, SEL_SPL_COL, SEL_SPL_PAGE,
    SEL_CUR_COL, SEL_CUR_PAGE
  } sel_e;

  typedef struct packed {
    act_e       act;
    logic       emit;
    sel_e       sel;
    logic       last;
    logic [2:0] row;
    logic [2:0] gi;
    logic       nxt;
  } cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       in_ok;
    logic       cur_ok;
    logic       split_cell;
    logic [2:0] split_at;
  } stat_t;

  // Font: five column bytes per glyph, first column in the top byte
  localparam logic [39:0] GLYPHS [96] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
    40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h1008181008, 40'h1C3E3E3E1C
  };

  function automatic logic [7:0] map_char(input logic [7:0] c);
    return (c >= 8'h20 && c <= 8'h7F) ? c : SPACE_CODE;
  endfunction

  // Column byte of a mapped character; column 5 and above give the blank column
  function automatic logic [7:0] glyph_byte(input logic [7:0] c, input logic [2:0] i);
    logic [6:0]  idx;
    logic [39:0] g;
    logic [7:0]  b;
    idx = 7'(c - SPACE_CODE);
    g   = GLYPHS[idx];
    case (i)
      3'd0:    b = g[39:32];
      3'd1:    b = g[31:24];
      3'd2:    b = g[23:16];
      3'd3:    b = g[15:8];
      3'd4:    b = g[7:0];
      default: b = BLANK_BYTE;
    endcase
    return b;
  endfunction

  // Pixel column of a 1-based text column: 6 * (col - 1)
  function automatic logic [7:0] px_of(input logic [5:0] col);
    logic [5:0] c;
    c = col - 6'd1;
    return 8'({c, 2'b00}) + 8'({c, 1'b0});
  endfunction

  function automatic logic [7:0] cell_of(input logic [5:0] col, input logic [3:0] row);
    logic [3:0] r;
    logic [5:0] c;
    r = row - 4'd1;
    c = col - 6'd1;
    return {r[2:0], c[4:0]};
  endfunction

endpackage

>>> design/gtcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gtcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> design/gtcr_ctrl.sv
// Sequencer for the text renderer: walks each request through its writes.
// Depends on gtcr_pkg.
module gtcr_ctrl #(
  parameter int unsigned TEXT_ROWS = gtcr_pkg::DEF_TEXT_ROWS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [2:0]          kind_i,
  output logic                in_stall_o,
  input  gtcr_pkg::stat_t     stat_i,
  output gtcr_pkg::cmd_t      cmd_o
);
  import gtcr_pkg::*;

  localparam logic [2:0] LAST_ROW = 3'(TEXT_ROWS - 1);

  state_e     state_q, state_d;
  job_e       job_q, job_d;
  logic [2:0] row_q, row_d;
  logic [2:0] gi_q, gi_d;
  logic       nxt_q, nxt_d;
  logic       adv;

  assign adv = stat_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JOB_INIT;
      row_q   <= '0;
      gi_q    <= '0;
      nxt_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      row_q   <= row_d;
      gi_q    <= gi_d;
      nxt_q   <= nxt_d;
    end
  end

  // Next state and counters
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    row_d   = row_q;
    gi_d    = gi_q;
    nxt_d   = nxt_q;
    case (state_q)
      ST_IDLE: begin
        row_d = '0;
        gi_d  = '0;
        nxt_d = 1'b0;
        if (in_valid_i) begin
          case (kind_i)
            K_INIT: begin
              state_d = ST_ON;
              job_d   = JOB_INIT;
            end
            K_PRINT: begin
              if (stat_i.cur_ok) begin
                state_d = ST_DRAW;
                job_d   = JOB_PRINT;
              end
            end
            K_MOVE: begin
              if (stat_i.in_ok) begin
                state_d = ST_CUR_COL;
                job_d   = JOB_MOVE;
              end
            end
            K_CLEAR: begin
              state_d = ST_CLR_PAGE;
              job_d   = JOB_CLEAR;
            end
            K_TICK: begin
              state_d = ST_PTR_COL;
              job_d   = JOB_TICK;
            end
            K_MPTR: begin
              if (stat_i.in_ok) begin
                state_d = ST_PTR_COL;
                job_d   = JOB_TICK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ON:       if (adv) state_d = ST_START;
      ST_START:    if (adv) state_d = ST_CLR_PAGE;
      ST_CLR_PAGE: if (adv) state_d = ST_CLR_COL;
      ST_CLR_COL:  if (adv) state_d = ST_CLR_DATA;
      ST_CLR_DATA: begin
        if (adv) begin
          if (row_q == LAST_ROW) begin
            state_d = (job_q == JOB_INIT) ? ST_CUR_COL : ST_IDLE;
          end else begin
            row_d   = row_q + 3'd1;
            state_d = ST_CLR_PAGE;
          end
        end
      end
      ST_PTR_COL:  if (adv) state_d = ST_PTR_PAGE;
      ST_PTR_PAGE: if (adv) state_d = ST_DRAW;
      ST_DRAW: begin
        if (adv) begin
          if (gi_q == 3'd5) begin
            if (job_q == JOB_TICK && stat_i.cur_ok) begin
              state_d = ST_CUR_COL;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            gi_d = gi_q + 3'd1;
            // straddling cell: re-address in the next segment mid-glyph
            if (stat_i.split_cell && !nxt_q && (gi_q + 3'd1) == stat_i.split_at) begin
              state_d = ST_SPL_COL;
            end
          end
        end
      end
      ST_SPL_COL:  if (adv) state_d = ST_SPL_PAGE;
      ST_SPL_PAGE: begin
        if (adv) begin
          state_d = ST_DRAW;
          nxt_d   = 1'b1;
        end
      end
      ST_CUR_COL:  if (adv) state_d = ST_CUR_PAGE;
      ST_CUR_PAGE: if (adv) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o      = '0;
    cmd_o.act  = ACT_NONE;
    cmd_o.sel  = SEL_ON;
    cmd_o.row  = row_q;
    cmd_o.gi   = gi_q;
    cmd_o.nxt  = nxt_q;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            K_INIT:  cmd_o.act = ACT_INIT;
            K_PRINT: cmd_o.act = stat_i.cur_ok ? ACT_PRINT : ACT_NONE;
            K_MOVE:  cmd_o.act = stat_i.in_ok ? ACT_MOVE : ACT_NONE;
            K_CLEAR: cmd_o.act = ACT_CLEAR;
            K_TICK:  cmd_o.act = ACT_TICK;
            K_MPTR:  cmd_o.act = stat_i.in_ok ? ACT_MPTR : ACT_NONE;
            default: cmd_o.act = ACT_NONE;
          endcase
        end
      end
      ST_ON: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_ON;
      end
      ST_START: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_START;
      end
      ST_CLR_PAGE: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_CLR_PAGE;
      end
      ST_CLR_COL: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_CLR_COL;
      end
      ST_CLR_DATA: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_CLR_DATA;
        cmd_o.last = (row_q == LAST_ROW) && (job_q == JOB_CLEAR);
      end
      ST_PTR_COL: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_PTR_COL;
      end
      ST_PTR_PAGE: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_PTR_PAGE;
      end
      ST_DRAW: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_GLYPH;
        cmd_o.last = (gi_q == 3'd5) && !(job_q == JOB_TICK && stat_i.cur_ok);
      end
      ST_SPL_COL: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_SPL_COL;
      end
      ST_SPL_PAGE: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_SPL_PAGE;
      end
      ST_CUR_COL: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_CUR_COL;
      end
      ST_CUR_PAGE: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_CUR_PAGE;
        cmd_o.last = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

>>> design/gtcr_dp.sv
// Datapath: cursor and pointer state, text store, glyph lookup, output register.
// Depends on gtcr_pkg and gtcr_ram.
module gtcr_dp #(
  parameter int unsigned TEXT_COLUMNS = gtcr_pkg::DEF_TEXT_COLUMNS,
  parameter int unsigned TEXT_ROWS    = gtcr_pkg::DEF_TEXT_ROWS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      character_i,
  input  logic [5:0]      column_i,
  input  logic [3:0]      row_i,
  input  logic            reset_flag_i,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i,
  input  gtcr_pkg::cmd_t  cmd_i,
  output gtcr_pkg::stat_t stat_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      operation_o,
  output logic [7:0]      value_o,
  output logic [1:0]      segment_o,
  output logic [6:0]      repeat_res_o,
  output logic            last_o
);
  import gtcr_pkg::*;

  localparam logic [5:0] MAX_COL = 6'(TEXT_COLUMNS);
  localparam logic [3:0] MAX_ROW = 4'(TEXT_ROWS);

  logic [7:0] ptr_sym_q;
  logic [5:0] cur_col_q, ptr_col_q, dcol_q;
  logic [3:0] cur_row_q, ptr_row_q, drow_q;
  logic       shown_q, use_store_q, vld_rd_q;
  logic [7:0] dchr_q;
  logic [STORE_DEPTH-1:0] vld_q;

  logic       out_valid_q, last_q;
  logic [2:0] op_q;
  logic [7:0] val_q;
  logic [1:0] seg_q;
  logic [6:0] rep_q;

  logic       out_free, load;
  logic       ram_we, ram_re;
  logic [7:0] waddr, raddr, rdata, wchar;
  logic [7:0] dchar, dpx, cpx;
  logic [1:0] dseg;
  logic [2:0] op_d;
  logic [7:0] val_d;
  logic [1:0] seg_d;
  logic [6:0] rep_d;
  logic       tick_act;

  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = cmd_i.emit && out_free;
  assign tick_act = (cmd_i.act == ACT_TICK) || (cmd_i.act == ACT_MPTR);

  assign stat_o.out_free   = out_free;
  assign stat_o.in_ok      = (column_i >= 6'd1) && (column_i <= MAX_COL) &&
                             (row_i >= 4'd1) && (row_i <= MAX_ROW);
  assign stat_o.cur_ok     = (cur_col_q >= 6'd1) && (cur_col_q <= MAX_COL) &&
                             (cur_row_q >= 4'd1) && (cur_row_q <= MAX_ROW);
  assign stat_o.split_cell = (dcol_q == SPLIT_A) || (dcol_q == SPLIT_B);
  assign stat_o.split_at   = (dcol_q == SPLIT_A) ? 3'd4 : 3'd2;

  assign wchar  = map_char(character_i);
  assign ram_we = (cmd_i.act == ACT_PRINT);
  assign waddr  = cell_of(cur_col_q, cur_row_q);
  assign ram_re = tick_act;
  assign raddr  = cell_of(ptr_col_q, ptr_row_q);

  gtcr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wchar),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // State updates happen when a request is accepted, and the pointer symbol also on a config write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_sym_q <= SPACE_CODE;
      cur_col_q <= 6'd1;
      cur_row_q <= 4'd1;
      ptr_col_q <= 6'd1;
      ptr_row_q <= 4'd1;
      shown_q   <= 1'b0;
      vld_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        ptr_sym_q <= cfg_wdata_i;
      end
      case (cmd_i.act)
        ACT_INIT: begin
          ptr_sym_q <= SPACE_CODE;
          cur_col_q <= 6'd1;
          cur_row_q <= 4'd1;
          ptr_col_q <= 6'd1;
          ptr_row_q <= 4'd1;
          vld_q     <= '0;
        end
        ACT_PRINT: begin
          vld_q[waddr] <= 1'b1;
          cur_col_q    <= cur_col_q + 6'd1;
        end
        ACT_MOVE: begin
          cur_col_q <= column_i;
          cur_row_q <= row_i;
        end
        ACT_CLEAR: vld_q <= '0;
        ACT_TICK:  shown_q <= !shown_q;
        ACT_MPTR: begin
          shown_q   <= !shown_q;
          ptr_col_q <= column_i;
          ptr_row_q <= row_i;
        end
        default: ;
      endcase
    end
  end

  // Draw position and character, latched at acceptance
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == ACT_PRINT) begin
      dcol_q      <= cur_col_q;
      drow_q      <= cur_row_q;
      dchr_q      <= wchar;
      use_store_q <= 1'b0;
    end else if (tick_act) begin
      dcol_q      <= ptr_col_q;
      drow_q      <= ptr_row_q;
      dchr_q      <= map_char(ptr_sym_q);
      use_store_q <= (cmd_i.act == ACT_MPTR) || reset_flag_i || !shown_q;
      vld_rd_q    <= vld_q[raddr];
    end
  end

  // A never-written cell reads as space
  assign dchar = use_store_q ? (vld_rd_q ? map_char(rdata) : SPACE_CODE) : dchr_q;
  assign dpx   = px_of(dcol_q);
  assign cpx   = px_of(cur_col_q);
  assign dseg  = dpx[7:6];

  always_comb begin
    op_d  = OP_DATA;
    val_d = BLANK_BYTE;
    seg_d = SEG_ALL;
    rep_d = 7'd1;
    case (cmd_i.sel)
      SEL_ON:       op_d = OP_ON;
      SEL_START:    op_d = OP_START;
      SEL_CLR_PAGE: begin
        op_d  = OP_PAGE;
        val_d = {5'd0, cmd_i.row};
      end
      SEL_CLR_COL:  op_d = OP_COL;
      SEL_CLR_DATA: rep_d = SEG_WIDTH;
      SEL_PTR_COL: begin
        op_d  = OP_COL;
        val_d = {2'b00, dpx[5:0]};
        seg_d = dseg;
      end
      SEL_PTR_PAGE: begin
        op_d  = OP_PAGE;
        val_d = {4'd0, drow_q - 4'd1};
        seg_d = dseg;
      end
      SEL_GLYPH: begin
        val_d = glyph_byte(dchar, cmd_i.gi);
        seg_d = dseg + {1'b0, cmd_i.nxt};
      end
      SEL_SPL_COL: begin
        op_d  = OP_COL;
        seg_d = dseg + 2'd1;
      end
      SEL_SPL_PAGE: begin
        op_d  = OP_PAGE;
        val_d = {4'd0, drow_q - 4'd1};
        seg_d = dseg + 2'd1;
      end
      SEL_CUR_COL: begin
        op_d  = OP_COL;
        val_d = {2'b00, cpx[5:0]};
        seg_d = cpx[7:6];
      end
      SEL_CUR_PAGE: begin
        op_d  = OP_PAGE;
        val_d = {4'd0, cur_row_q - 4'd1};
        seg_d = cpx[7:6];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q   <= op_d;
      val_q  <= val_d;
      seg_q  <= seg_d;
      rep_q  <= rep_d;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign operation_o  = op_q;
  assign value_o      = val_q;
  assign segment_o    = seg_q;
  assign repeat_res_o = rep_q;
  assign last_o       = last_q;
endmodule

>>> design/glcd_text_cursor_renderer.sv
// Text renderer for a 192x64 panel of three 64-column controller segments.
// Top level: joins the sequencer (gtcr_ctrl) and the datapath (gtcr_dp); uses gtcr_pkg.
//
// Each accepted request turns into a run of controller writes, delivered one per cycle
// through a single output register unless the output stalls; a request occupies the
// block until its last write is loaded: print 6 writes (8 for the cells straddling
// segments at columns 11 and 22), move cursor 2, clear 24, init 28, pointer tick and
// move pointer up to 12. A stall on the output holds the sequencer. Ignored requests
// (bad targets, printing past the last column, unknown kinds) produce nothing. The text
// store is a 256x8 RAM with a per-cell valid bit, so clear and init take effect at once.
module glcd_text_cursor_renderer #(
  parameter int unsigned TEXT_COLUMNS = gtcr_pkg::DEF_TEXT_COLUMNS,
  parameter int unsigned TEXT_ROWS    = gtcr_pkg::DEF_TEXT_ROWS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] character_i,
  input  logic [5:0] column_i,
  input  logic [3:0] row_i,
  input  logic       reset_flag_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] operation_o,
  output logic [7:0] value_o,
  output logic [1:0] segment_o,
  output logic [6:0] repeat_res_o,
  output logic       last_o
);
  import gtcr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gtcr_ctrl #(
    .TEXT_ROWS (TEXT_ROWS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gtcr_dp #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .character_i  (character_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .reset_flag_i (reset_flag_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .operation_o  (operation_o),
    .value_o      (value_o),
    .segment_o    (segment_o),
    .repeat_res_o (repeat_res_o),
    .last_o       (last_o)
  );
endmodule

>>> dv/glcd_text_cursor_renderer_tb.sv
// Self-checking testbench for glcd_text_cursor_renderer.
// Needs gtcr_pkg and the renderer RTL; carries its own prediction of the controller writes.
`timescale 1ns / 100ps

module glcd_text_cursor_renderer_tb;
  import gtcr_pkg::*;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] val;
    logic [1:0] seg;
    logic [6:0] rep;
    logic       last;
  } lcd_write_t;

  localparam int NCOLS = 32;
  localparam int NROWS = 8;
  localparam int CYCLE_LIMIT = 400000;

  // Predicts controller writes and holds the ones not yet seen
  class lcd_write_board;
    lcd_write_t pending[$];
    bit [7:0] font[96][5];
    bit [7:0] ptr_sym;
    bit [5:0] cur_col, ptr_col;
    bit [3:0] cur_row, ptr_row;
    bit       ptr_on;
    bit [7:0] store[256];
    int       n_bad;

    function new();
      foreach (GLYPHS[i])
        for (int j = 0; j < 5; j++) font[i][j] = GLYPHS[i][39 - 8*j -: 8];
      ptr_sym = SPACE_CODE; cur_col = 1; cur_row = 1; ptr_col = 1; ptr_row = 1;
      ptr_on = 0; n_bad = 0;
      foreach (store[i]) store[i] = SPACE_CODE;
    endfunction

    function void push(bit [2:0] op, int val, int seg, int rep);
      lcd_write_t w;
      w.op = op; w.val = val[7:0]; w.seg = seg[1:0]; w.rep = rep[6:0]; w.last = 0;
      pending.push_back(w);
    endfunction

    function bit col_ok(int c); return c >= 1 && c <= NCOLS; endfunction
    function bit row_ok(int r); return r >= 1 && r <= NROWS; endfunction
    function int cell_idx(int c, int r);
      return (((r - 1) & 7) << 5) | ((c - 1) & 31);
    endfunction
    function bit [7:0] printable(bit [7:0] c);
      return (c >= 8'h20 && c <= 8'h7F) ? c : SPACE_CODE;
    endfunction

    function void address(int c, int r);
      int px;
      px = 6 * (c - 1);
      push(OP_COL, px % 64, px / 64, 1);
      push(OP_PAGE, r - 1, px / 64, 1);
    endfunction

    function void glyph(bit [7:0] ch, bit keep);
      int c, r, px, sg, split;
      bit [7:0] m;
      c = cur_col; r = cur_row;
      if (!col_ok(c) || !row_ok(r)) return;
      m = printable(ch);
      px = 6 * (c - 1); sg = px / 64;
      if (c == SPLIT_A || c == SPLIT_B) begin
        split = (c == SPLIT_A) ? 4 : 2;
        for (int i = 0; i < split; i++) push(OP_DATA, font[m - 8'h20][i], sg, 1);
        push(OP_COL, 0, sg + 1, 1);
        push(OP_PAGE, r - 1, sg + 1, 1);
        for (int i = split; i < 5; i++) push(OP_DATA, font[m - 8'h20][i], sg + 1, 1);
        push(OP_DATA, BLANK_BYTE, sg + 1, 1);
      end else begin
        for (int i = 0; i < 5; i++) push(OP_DATA, font[m - 8'h20][i], sg, 1);
        push(OP_DATA, BLANK_BYTE, sg, 1);
      end
      if (keep) store[cell_idx(c, r)] = m;
      cur_col = 6'(c + 1);
    endfunction

    function void wipe();
      for (int r = 0; r < NROWS; r++) begin
        push(OP_PAGE, r, SEG_ALL, 1);
        push(OP_COL, 0, SEG_ALL, 1);
        push(OP_DATA, BLANK_BYTE, SEG_ALL, 64);
      end
      foreach (store[i]) store[i] = SPACE_CODE;
    endfunction

    function void blink(bit restore);
      bit [5:0] oc;
      bit [3:0] orow;
      oc = cur_col; orow = cur_row;
      address(ptr_col, ptr_row);
      cur_col = ptr_col; cur_row = ptr_row;
      if (restore || !ptr_on) glyph(store[cell_idx(ptr_col, ptr_row)], 0);
      else glyph(ptr_sym, 0);
      cur_col = oc; cur_row = orow;
      if (col_ok(oc) && row_ok(orow)) address(oc, orow);
      ptr_on = !ptr_on;
    endfunction

    // Notes an accepted request and queues the writes it should cause
    function void note_request(bit [2:0] k, bit [7:0] ch, bit [5:0] c, bit [3:0] r, bit rf);
      int n0;
      n0 = pending.size();
      case (k)
        K_INIT: begin
          push(OP_ON, 0, SEG_ALL, 1);
          push(OP_START, 0, SEG_ALL, 1);
          ptr_col = 1; ptr_row = 1; ptr_sym = SPACE_CODE;
          wipe();
          address(1, 1);
          cur_col = 1; cur_row = 1;
        end
        K_PRINT: glyph(ch, 1);
        K_MOVE: if (col_ok(c) && row_ok(r)) begin
          address(c, r); cur_col = c; cur_row = r;
        end
        K_CLEAR: wipe();
        K_TICK: blink(rf);
        K_MPTR: if (col_ok(c) && row_ok(r)) begin
          blink(1); ptr_col = c; ptr_row = r;
        end
        default: ;
      endcase
      if (pending.size() > n0) pending[pending.size() - 1].last = 1;
    endfunction

    function void check_write(lcd_write_t got);
      lcd_write_t e;
      if (pending.size() == 0) begin
        $error("unexpected write op=%0d val=%0h", got.op, got.val);
        n_bad++;
        return;
      end
      e = pending.pop_front();
      if (got.op != e.op) begin $error("operation exp %0d got %0d", e.op, got.op); n_bad++; end
      if (got.val != e.val) begin $error("value exp %0h got %0h", e.val, got.val); n_bad++; end
      if (got.seg != e.seg) begin $error("segment exp %0d got %0d", e.seg, got.seg); n_bad++; end
      if (got.rep != e.rep) begin
        $error("repeat_res exp %0d got %0d", e.rep, got.rep); n_bad++;
      end
      if (got.last != e.last) begin $error("last exp %0b got %0b", e.last, got.last); n_bad++; end
    endfunction
  endclass

  logic       clk_i = 0, rst_ni = 0;
  logic       cfg_we_i = 0;
  logic [7:0] cfg_wdata_i = 0;
  logic       in_valid_i = 0, in_stall_o;
  logic [2:0] kind_i = 0;
  logic [7:0] character_i = 0;
  logic [5:0] column_i = 0;
  logic [3:0] row_i = 0;
  logic       reset_flag_i = 0;
  logic       out_valid_o, out_stall_i = 0;
  logic [2:0] operation_o;
  logic [7:0] value_o;
  logic [1:0] segment_o;
  logic [6:0] repeat_res_o;
  logic       last_o;

  lcd_write_board board = new();
  bit idle_on = 1;
  int cycles = 0;

  glcd_text_cursor_renderer u_dut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  // Output side: random stalls, check on every accepted write
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_write({operation_o, value_o, segment_o, repeat_res_o, last_o});
    out_stall_i <= idle_on && ($urandom_range(99) < 13);
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Valid stays high between back-to-back requests; it drops only for an idle gap
  task automatic send(bit [2:0] k, bit [7:0] ch, bit [5:0] c, bit [3:0] r, bit rf);
    if (idle_on && $urandom_range(99) < 13) begin
      in_valid_i <= 0;
      @(posedge clk_i);
      while (idle_on && $urandom_range(99) < 13) @(posedge clk_i);
    end
    in_valid_i <= 1; kind_i <= k; character_i <= ch;
    column_i <= c; row_i <= r; reset_flag_i <= rf;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(k, ch, c, r, rf);
  endtask

  // Waits for all writes, then extra cycles for ignored requests still in flight
  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_symbol(bit [7:0] s);
    drain();
    cfg_we_i <= 1; cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i <= 0;
    board.ptr_sym = s;
  endtask

  task automatic random_request();
    int p;
    bit [5:0] c;
    bit [3:0] r;
    p = $urandom_range(99);
    c = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(NCOLS, 1));
    r = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(NROWS, 1));
    if (p < 50) send(K_PRINT, 8'($urandom), c, r, $urandom);
    else if (p < 62) send(K_MOVE, $urandom, c, r, $urandom);
    else if (p < 76) send(K_TICK, $urandom, c, r, $urandom);
    else if (p < 88) send(K_MPTR, $urandom, c, r, $urandom);
    else if (p < 92) send(K_CLEAR, $urandom, c, r, $urandom);
    else if (p < 94) send(K_INIT, $urandom, c, r, $urandom);
    else send(3'($urandom_range(7, 6)), $urandom, c, r, $urandom);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    set_symbol(8'h7F);
    // Directed: init, segment-straddling cells, edges and ignored requests
    send(K_INIT, 0, 0, 0, 0);
    send(K_MOVE, 0, 10, 1, 0);
    send(K_PRINT, 8'h41, 0, 0, 0);
    send(K_PRINT, 8'h00, 0, 0, 0);
    send(K_PRINT, 8'hFF, 0, 0, 0);
    send(K_MOVE, 0, 22, 8, 0);
    send(K_PRINT, 8'h7F, 0, 0, 0);
    send(K_MOVE, 0, 32, 8, 0);
    send(K_PRINT, 8'h20, 0, 0, 0);
    send(K_PRINT, 8'h42, 0, 0, 0);
    send(K_TICK, 0, 0, 0, 0);
    send(K_MOVE, 0, 0, 1, 0);
    send(K_MOVE, 0, 33, 9, 0);
    send(K_MOVE, 0, 63, 15, 0);
    send(K_MPTR, 0, 11, 1, 0);
    send(K_TICK, 0, 0, 0, 0);
    send(K_TICK, 0, 0, 0, 0);
    send(K_TICK, 0, 0, 0, 1);
    send(K_MPTR, 0, 40, 0, 0);
    send(K_CLEAR, 0, 0, 0, 0);
    send(3'd6, 8'hFF, 63, 15, 1);
    send(3'd7, 0, 0, 0, 0);
    set_symbol(8'h00);
    send(K_MPTR, 0, 22, 8, 0);
    send(K_TICK, 0, 0, 0, 0);
    send(K_TICK, 0, 0, 0, 0);
    set_symbol(8'hFF);
    for (int i = 0; i < 320; i++) begin
      if (i == 100) idle_on = 0;
      if (i == 160) idle_on = 1;
      if (i % 80 == 79) set_symbol(8'($urandom));
      random_request();
    end
    drain();
    if (board.n_bad == 0 && board.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

>>> glcd_text_cursor_renderer.f
design/gtcr_pkg.sv
design/gtcr_ram.sv
design/gtcr_ctrl.sv
design/gtcr_dp.sv
design/glcd_text_cursor_renderer.sv
dv/glcd_text_cursor_renderer_tb.sv
